// ===== rtl/drr_pkg.sv =====
`timescale 1ns / 1ps

package drr_pkg;

    // item actions
    localparam logic [1:0] ACT_ROTATE = 2'd0;
    localparam logic [1:0] ACT_RENORM = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [1:0] NUM_ROWS   = 2'd3;

    // operand selectors: matrix, scratch, increment, half error, zero
    typedef logic [4:0] sel_t;
    localparam int   NUM_SEL  = 23;
    localparam sel_t SEL_M0   = 5'd0;
    localparam sel_t SEL_M1   = 5'd1;
    localparam sel_t SEL_M2   = 5'd2;
    localparam sel_t SEL_M3   = 5'd3;
    localparam sel_t SEL_M4   = 5'd4;
    localparam sel_t SEL_M5   = 5'd5;
    localparam sel_t SEL_M6   = 5'd6;
    localparam sel_t SEL_M7   = 5'd7;
    localparam sel_t SEL_M8   = 5'd8;
    localparam sel_t SEL_T0   = 5'd9;
    localparam sel_t SEL_T1   = 5'd10;
    localparam sel_t SEL_T2   = 5'd11;
    localparam sel_t SEL_T3   = 5'd12;
    localparam sel_t SEL_T4   = 5'd13;
    localparam sel_t SEL_T5   = 5'd14;
    localparam sel_t SEL_T6   = 5'd15;
    localparam sel_t SEL_T7   = 5'd16;
    localparam sel_t SEL_T8   = 5'd17;
    localparam sel_t SEL_VX   = 5'd18;
    localparam sel_t SEL_VY   = 5'd19;
    localparam sel_t SEL_VZ   = 5'd20;
    localparam sel_t SEL_HALF = 5'd21;
    localparam sel_t SEL_ZERO = 5'd22;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL,
        ST_ACC,
        ST_STORE,
        ST_ROOT,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        JK_ROUND,
        JK_HALF,
        JK_SQ,
        JK_END
    } job_kind_t;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_mode_t;

    // one sum-of-products job
    typedef struct packed {
        job_kind_t  kind;
        sel_t       base;
        sel_t [2:0] xs;
        sel_t [2:0] ys;
        logic [2:0] neg;
        logic [1:0] last_term;
        logic [3:0] dest;
        logic [1:0] row;
    } job_t;

    typedef struct packed {
        logic init;
        logic mul;
        logic acc;
        logic neg;
    } mac_ctl_t;

    typedef struct packed {
        logic     start;
        rd_mode_t mode;
    } rd_ctl_t;

    function automatic job_t mk_job(job_kind_t k, sel_t b, sel_t x0, sel_t y0, sel_t x1,
                                    sel_t y1, sel_t x2, sel_t y2, logic [2:0] ng,
                                    logic [1:0] lt, logic [3:0] dst, logic [1:0] rw);
        job_t j;
        j.kind      = k;
        j.base      = b;
        j.xs[0]     = x0;
        j.ys[0]     = y0;
        j.xs[1]     = x1;
        j.ys[1]     = y1;
        j.xs[2]     = x2;
        j.ys[2]     = y2;
        j.neg       = ng;
        j.last_term = lt;
        j.dest      = dst;
        j.row       = rw;
        return j;
    endfunction

    // job lists for rotate and renormalize
    function automatic job_t job_lookup(logic renorm, logic [3:0] idx);
        job_t j;
        j = mk_job(JK_END, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO,
                   SEL_ZERO, 3'b000, 2'd0, 4'd0, 2'd0);
        if (!renorm)
        begin
            case (idx)
                4'd0: j = mk_job(JK_ROUND, SEL_M0, SEL_M1, SEL_VZ, SEL_M2, SEL_VY, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd0, 2'd0);
                4'd1: j = mk_job(JK_ROUND, SEL_M1, SEL_M2, SEL_VX, SEL_M0, SEL_VZ, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd1, 2'd0);
                4'd2: j = mk_job(JK_ROUND, SEL_M2, SEL_M0, SEL_VY, SEL_M1, SEL_VX, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd2, 2'd0);
                4'd3: j = mk_job(JK_ROUND, SEL_M3, SEL_M4, SEL_VZ, SEL_M5, SEL_VY, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd3, 2'd0);
                4'd4: j = mk_job(JK_ROUND, SEL_M4, SEL_M5, SEL_VX, SEL_M3, SEL_VZ, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd4, 2'd0);
                4'd5: j = mk_job(JK_ROUND, SEL_M5, SEL_M3, SEL_VY, SEL_M4, SEL_VX, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd5, 2'd0);
                4'd6: j = mk_job(JK_ROUND, SEL_M6, SEL_M7, SEL_VZ, SEL_M8, SEL_VY, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd6, 2'd0);
                4'd7: j = mk_job(JK_ROUND, SEL_M7, SEL_M8, SEL_VX, SEL_M6, SEL_VZ, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd7, 2'd0);
                4'd8: j = mk_job(JK_ROUND, SEL_M8, SEL_M6, SEL_VY, SEL_M7, SEL_VX, SEL_ZERO,
                                 SEL_ZERO, 3'b010, 2'd1, 4'd8, 2'd0);
                default: ;
            endcase
        end
        else
        begin
            case (idx)
                // error is the dot product of rows one and two
                4'd0:  j = mk_job(JK_HALF, SEL_ZERO, SEL_M0, SEL_M3, SEL_M1, SEL_M4, SEL_M2,
                                  SEL_M5, 3'b000, 2'd2, 4'd0, 2'd0);
                4'd1:  j = mk_job(JK_ROUND, SEL_M0, SEL_HALF, SEL_M3, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd0, 2'd0);
                4'd2:  j = mk_job(JK_ROUND, SEL_M3, SEL_HALF, SEL_M0, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd3, 2'd0);
                4'd3:  j = mk_job(JK_ROUND, SEL_M1, SEL_HALF, SEL_M4, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd1, 2'd0);
                4'd4:  j = mk_job(JK_ROUND, SEL_M4, SEL_HALF, SEL_M1, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd4, 2'd0);
                4'd5:  j = mk_job(JK_ROUND, SEL_M2, SEL_HALF, SEL_M5, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd2, 2'd0);
                4'd6:  j = mk_job(JK_ROUND, SEL_M5, SEL_HALF, SEL_M2, SEL_ZERO, SEL_ZERO,
                                  SEL_ZERO, SEL_ZERO, 3'b001, 2'd0, 4'd5, 2'd0);
                // cross product of the corrected rows
                4'd7:  j = mk_job(JK_ROUND, SEL_ZERO, SEL_T1, SEL_T5, SEL_T2, SEL_T4, SEL_ZERO,
                                  SEL_ZERO, 3'b010, 2'd1, 4'd6, 2'd0);
                4'd8:  j = mk_job(JK_ROUND, SEL_ZERO, SEL_T2, SEL_T3, SEL_T0, SEL_T5, SEL_ZERO,
                                  SEL_ZERO, 3'b010, 2'd1, 4'd7, 2'd0);
                4'd9:  j = mk_job(JK_ROUND, SEL_ZERO, SEL_T0, SEL_T4, SEL_T1, SEL_T3, SEL_ZERO,
                                  SEL_ZERO, 3'b010, 2'd1, 4'd8, 2'd0);
                // squared row lengths
                4'd10: j = mk_job(JK_SQ, SEL_ZERO, SEL_T0, SEL_T0, SEL_T1, SEL_T1, SEL_T2,
                                  SEL_T2, 3'b000, 2'd2, 4'd0, 2'd0);
                4'd11: j = mk_job(JK_SQ, SEL_ZERO, SEL_T3, SEL_T3, SEL_T4, SEL_T4, SEL_T5,
                                  SEL_T5, 3'b000, 2'd2, 4'd0, 2'd1);
                4'd12: j = mk_job(JK_SQ, SEL_ZERO, SEL_T6, SEL_T6, SEL_T7, SEL_T7, SEL_T8,
                                  SEL_T8, 3'b000, 2'd2, 4'd0, 2'd2);
                default: ;
            endcase
        end
        return j;
    endfunction

endpackage

// ===== rtl/drr_mac.sv =====
`timescale 1ns / 1ps

module drr_mac #(
    parameter int FRAC_BITS = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drr_pkg::mac_ctl_t   ctl,
    input  logic signed [31:0]  base,
    input  logic signed [31:0]  x,
    input  logic signed [31:0]  y,
    output logic signed [31:0]  rounded,
    output logic                sat,
    output logic [63:0]         raw
);
    import drr_pkg::*;

    localparam int ACC_W = ((32 + FRAC_BITS > 64) ? 32 + FRAC_BITS : 64) + 3;
    localparam int EXT_W = ACC_W - 32 - FRAC_BITS;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] shifted;
    logic                    in_range;

    // accumulator: base scaled up, then signed products added or subtracted exactly
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.init)
        begin
            acc_next = {{EXT_W{base[31]}}, base, {FRAC_BITS{1'b0}}};
        end
        else if (ctl.acc)
        begin
            acc_next = ctl.neg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= x * y;
        end
    end

    // floor shift and saturate
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign in_range = (&shifted[ACC_W-1:31]) | ~(|shifted[ACC_W-1:31]);
    assign sat      = ~in_range;
    assign rounded  = in_range ? shifted[31:0]
                    : (shifted[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    assign raw      = acc_reg[63:0];

endmodule

// ===== rtl/drr_root_div.sv =====
`timescale 1ns / 1ps

module drr_root_div #(
    parameter int FRAC_BITS = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drr_pkg::rd_ctl_t    ctl,
    input  logic [63:0]         radicand,
    input  logic signed [31:0]  dvd,
    input  logic [31:0]         dvs,
    output logic                done,
    output logic [31:0]         root,
    output logic signed [31:0]  quot,
    output logic                quot_ovf
);
    import drr_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW);

    rd_mode_t      mode_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [32:0]   rem_reg;
    logic [63:0]   sh_reg;
    logic [32:0]   q_reg;
    logic          big_reg;
    logic          neg_reg;
    logic [31:0]   m_reg;

    logic [34:0]   rem_shift;
    logic [34:0]   trial;
    logic [35:0]   diff;
    logic          take;
    logic [31:0]   mag;

    // shared compare and subtract step
    always_comb
    begin
        if (mode_reg == RD_SQRT)
        begin
            rem_shift = {rem_reg, sh_reg[63:62]};
            trial     = {1'b0, q_reg[31:0], 2'b01};
        end
        else
        begin
            rem_shift = {1'b0, rem_reg, sh_reg[63]};
            trial     = {3'b000, m_reg};
        end
        diff = {1'b0, rem_shift} - {1'b0, trial};
        take = ~diff[35];
    end

    assign mag = dvd[31] ? 32'(-dvd) : 32'(dvd);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= RD_SQRT;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= ctl.mode;
                cnt_reg  <= (ctl.mode == RD_SQRT) ? CW'(31) : CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= dvd[31];
            m_reg   <= dvs;
            sh_reg  <= (ctl.mode == RD_SQRT) ? radicand : {mag, 32'd0};
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[32:0] : rem_shift[32:0];
            q_reg   <= {q_reg[31:0], take};
            big_reg <= big_reg | q_reg[32];
            sh_reg  <= (mode_reg == RD_SQRT) ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
        end
    end

    // signed and saturated quotient
    always_comb
    begin
        if (neg_reg)
        begin
            quot_ovf = big_reg | q_reg[32] | (q_reg[31] & (|q_reg[30:0]));
            quot     = quot_ovf ? 32'sh8000_0000 : -$signed(q_reg[31:0]);
        end
        else
        begin
            quot_ovf = big_reg | q_reg[32] | q_reg[31];
            quot     = quot_ovf ? 32'sh7fff_ffff : $signed(q_reg[31:0]);
        end
    end

    assign done = done_reg;
    assign root = q_reg[31:0];

endmodule

// ===== rtl/dcm_rotate_and_renormalize_unit.sv =====
`timescale 1ns / 1ps

// Holds a 3x3 attitude matrix in signed fixed point (FRAC_BITS fraction bits,
// identity after reset) and answers every accepted word with all nine entries
// and an overflow flag. Action 0 rotates by a small angle increment, action 1
// renormalizes (orthogonality correction, cross product, unit length rows),
// action 2 loads one row and action 3 changes nothing. One word is worked at
// a time; in_stall stays high until the result word is taken. Everything runs
// through one shared 32x32 multiply-accumulate unit and one shared
// shift-subtract unit for square root and division. Rotate forms nine sums
// of two products; renormalize divides each row by its length, one quotient
// bit per cycle over 32+FRAC_BITS bits in each of its three divisions.
module dcm_rotate_and_renormalize_unit #(
    parameter int FRAC_BITS = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic signed [31:0]  vec_x,
    input  logic signed [31:0]  vec_y,
    input  logic signed [31:0]  vec_z,
    input  logic [1:0]          row_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_xx,
    output logic signed [31:0]  out_xy,
    output logic signed [31:0]  out_xz,
    output logic signed [31:0]  out_yx,
    output logic signed [31:0]  out_yy,
    output logic signed [31:0]  out_yz,
    output logic signed [31:0]  out_zx,
    output logic signed [31:0]  out_zy,
    output logic signed [31:0]  out_zz,
    output logic                overflow
);
    import drr_pkg::*;

    localparam logic [31:0] ONE_Q = (FRAC_BITS >= 31) ? 32'h7fff_ffff
                                  : 32'(64'd1 << FRAC_BITS);

    state_t             state_reg;
    state_t             state_next;
    logic signed [31:0] mat_reg [9];
    logic signed [31:0] tmp_reg [9];
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vz_reg;
    logic signed [31:0] half_reg;
    logic [31:0]        root_reg;
    logic               renorm_reg;
    logic               ovf_reg;
    logic [3:0]         job_reg;
    logic [1:0]         term_reg;
    logic [1:0]         col_reg;

    job_t               job;
    logic               in_acc;
    logic signed [31:0] opnd [NUM_SEL];
    logic [3:0]         div_idx;
    logic [3:0]         load_idx;
    mac_ctl_t           mac_ctl;
    rd_ctl_t            rd_ctl;
    logic signed [31:0] mac_rounded;
    logic               mac_sat;
    logic [63:0]        mac_raw;
    logic               rd_done;
    logic [31:0]        rd_root;
    logic signed [31:0] rd_quot;
    logic               rd_quot_ovf;

    assign in_acc   = in_valid & ~in_stall;
    assign job      = job_lookup(renorm_reg, job_reg);
    assign div_idx  = {2'b00, job.row} + {1'b0, job.row, 1'b0} + {2'b00, col_reg};
    assign load_idx = {2'b00, row_index} + {1'b0, row_index, 1'b0};

    // operand file
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            opnd[i]     = mat_reg[i];
            opnd[9 + i] = tmp_reg[i];
        end
        opnd[SEL_VX]   = vx_reg;
        opnd[SEL_VY]   = vy_reg;
        opnd[SEL_VZ]   = vz_reg;
        opnd[SEL_HALF] = half_reg;
        opnd[SEL_ZERO] = '0;
    end

    drr_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .base    (opnd[job.base]),
        .x       (opnd[job.xs[term_reg]]),
        .y       (opnd[job.ys[term_reg]]),
        .rounded (mac_rounded),
        .sat     (mac_sat),
        .raw     (mac_raw)
    );

    drr_root_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_root_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rd_ctl),
        .radicand (mac_raw),
        .dvd      (tmp_reg[div_idx]),
        .dvs      (root_reg),
        .done     (rd_done),
        .root     (rd_root),
        .quot     (rd_quot),
        .quot_ovf (rd_quot_ovf)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_ROTATE || action == ACT_RENORM)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INIT:   state_next = (job.kind == JK_END) ? ST_DONE : ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (term_reg == job.last_term) ? ST_STORE : ST_MUL;
            ST_STORE:  state_next = (job.kind == JK_SQ) ? ST_ROOT : ST_INIT;
            ST_ROOT:
            begin
                if (rd_done)
                begin
                    state_next = (rd_root == '0) ? ST_INIT : ST_DIV_GO;
                end
            end
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:
            begin
                if (rd_done)
                begin
                    state_next = (col_reg == 2'd2) ? ST_INIT : ST_DIV_GO;
                end
            end
            ST_DONE:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        mac_ctl      = '0;
        rd_ctl.start = 1'b0;
        rd_ctl.mode  = RD_SQRT;
        unique case (state_reg)
            ST_INIT: mac_ctl.init = 1'b1;
            ST_MUL:  mac_ctl.mul  = 1'b1;
            ST_ACC:
            begin
                mac_ctl.acc = 1'b1;
                mac_ctl.neg = job.neg[term_reg];
            end
            ST_STORE:
            begin
                rd_ctl.start = (job.kind == JK_SQ);
            end
            ST_DIV_GO:
            begin
                rd_ctl.start = 1'b1;
                rd_ctl.mode  = RD_DIV;
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // matrix and sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                mat_reg[i] <= (i % 4 == 0) ? ONE_Q : '0;
            end
            ovf_reg    <= 1'b0;
            renorm_reg <= 1'b0;
            job_reg    <= '0;
            term_reg   <= '0;
            col_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        ovf_reg    <= 1'b0;
                        job_reg    <= '0;
                        renorm_reg <= (action == ACT_RENORM);
                        if (action == ACT_LOAD && row_index < NUM_ROWS)
                        begin
                            mat_reg[load_idx]        <= vec_x;
                            mat_reg[load_idx + 4'd1] <= vec_y;
                            mat_reg[load_idx + 4'd2] <= vec_z;
                        end
                    end
                end
                ST_INIT:
                begin
                    term_reg <= '0;
                end
                ST_ACC:
                begin
                    if (term_reg != job.last_term)
                    begin
                        term_reg <= term_reg + 1'b1;
                    end
                end
                ST_STORE:
                begin
                    if (job.kind != JK_SQ)
                    begin
                        ovf_reg <= ovf_reg | mac_sat;
                        job_reg <= job_reg + 1'b1;
                    end
                end
                ST_ROOT:
                begin
                    if (rd_done)
                    begin
                        col_reg <= '0;
                        if (rd_root == '0)
                        begin
                            ovf_reg <= 1'b1;
                            job_reg <= job_reg + 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (rd_done)
                    begin
                        ovf_reg <= ovf_reg | rd_quot_ovf;
                        if (col_reg == 2'd2)
                        begin
                            job_reg <= job_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        mat_reg[i] <= tmp_reg[i];
                    end
                end
                default: ;
            endcase
        end
    end

    // scratch values
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            vx_reg <= vec_x;
            vy_reg <= vec_y;
            vz_reg <= vec_z;
        end
        if (state_reg == ST_STORE && job.kind == JK_ROUND)
        begin
            tmp_reg[job.dest] <= mac_rounded;
        end
        if (state_reg == ST_STORE && job.kind == JK_HALF)
        begin
            half_reg <= mac_rounded >>> 1;
        end
        if (state_reg == ST_ROOT && rd_done)
        begin
            root_reg <= rd_root;
        end
        if (state_reg == ST_DIV && rd_done)
        begin
            tmp_reg[div_idx] <= rd_quot;
        end
    end

    // result word
    assign out_xx   = mat_reg[0];
    assign out_xy   = mat_reg[1];
    assign out_xz   = mat_reg[2];
    assign out_yx   = mat_reg[3];
    assign out_yy   = mat_reg[4];
    assign out_yz   = mat_reg[5];
    assign out_zx   = mat_reg[6];
    assign out_zy   = mat_reg[7];
    assign out_zz   = mat_reg[8];
    assign overflow = ovf_reg;

endmodule
